// File: hdl/ftcm_pkg.sv
// shared types, codes and constants of the force/torque calibration matrix
package ftcm_pkg;

  // default sizes of the calibration matrix
  localparam int AXES_DEFAULT  = 6;
  localparam int GAGES_DEFAULT = 6;

  // number of gage fields carried by one input item
  localparam int GAGE_FIELDS = 6;

  // arithmetic widths
  localparam int GAGE_W   = 16;
  localparam int CORR_W   = 17;
  localparam int COEF_W   = 24;
  localparam int MUL_W    = 41;
  localparam int SUM_W    = 45;
  localparam int SG_W     = 49;
  localparam int PP_SPLIT = 24;
  localparam int OP_W     = 26;
  localparam int PP_W     = 52;
  localparam int P_W      = 94;
  localparam int VAL_W    = 32;

  // configuration port
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_AXES  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_GAGES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_FACTOR  = 2'd2;
  localparam logic [23:0] GAIN_RESET = 24'd65536;

  // item kinds
  localparam logic [2:0] KIND_SAMPLE = 3'd0;
  localparam logic [2:0] KIND_TARE   = 3'd1;
  localparam logic [2:0] KIND_CLEAR  = 3'd2;
  localparam logic [2:0] KIND_COEF   = 3'd3;
  localparam logic [2:0] KIND_SCALE  = 3'd4;

  typedef struct packed {
    logic [2:0]         kind;
    logic signed [15:0] gage_0;
    logic signed [15:0] gage_1;
    logic signed [15:0] gage_2;
    logic signed [15:0] gage_3;
    logic signed [15:0] gage_4;
    logic signed [15:0] gage_5;
    logic [2:0]         row;
    logic [2:0]         column;
    logic signed [23:0] coefficient;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         axis;
    logic signed [31:0] value;
    logic               saturated;
    logic               last;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_DOT,
    S_WAIT,
    S_PP,
    S_PPEND,
    S_OUT
  } ctrl_state_t;

  // controller to datapath
  typedef struct packed {
    logic       take;
    logic       axis_start;
    logic       issue;
    logic       pp_step;
    logic       out_load;
    logic [2:0] axis;
    logic [2:0] gidx;
    logic [1:0] pp_sel;
    logic       last;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic       start;
    logic [2:0] na;
    logic [2:0] ng;
    logic       pipe_busy;
    logic       out_free;
  } dp_sts_t;

endpackage

// File: hdl/force_torque_calibration_matrix.sv
// top level of the six-axis force/torque calibration matrix
// the next item is taken once the last axis result is loaded; the pace is set by the
//   single-read coefficient memory and the shared four-step partial-product multiplier
// tare, clear and table-write items are taken while idle and do not start the sequencer
// reset (rst_n low, synchronous) clears coefficient valid bits, scales, bias and config; no clearing pass
module force_torque_calibration_matrix #(
  parameter int AXES  = ftcm_pkg::AXES_DEFAULT,
  parameter int GAGES = ftcm_pkg::GAGES_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  ftcm_pkg::in_item_t             in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output ftcm_pkg::out_item_t            out_data,
  input  logic                           cfg_we,
  input  logic [ftcm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ftcm_pkg::CFG_W-1:0]     cfg_data
);
  import ftcm_pkg::*;

  localparam int NA_MAX = (AXES < GAGE_FIELDS) ? AXES : GAGE_FIELDS;

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  ftcm_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  ftcm_dp #(
    .AXES  (AXES),
    .GAGES (GAGES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // items are taken only while the sequencer is idle
  assign in_stall = ~cmd.take;

  // commands of the sequencer never overlap
  a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.take, cmd.axis_start, cmd.issue, cmd.pp_step, cmd.out_load}))
    else $error("overlapping sequencer commands");

  // a result only appears while a sample is in work
  a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(cmd.take))
    else $error("result loaded while idle");

  // reported axis stays inside the computed axes
  a_out_axis: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.axis < 3'(NA_MAX)))
    else $error("result axis out of range");

endmodule

// File: hdl/ftcm_ram.sv
// generic single-port-write, registered-read ram
module ftcm_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 36,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hdl/ftcm_ctrl.sv
// sequencer over axes, gages and partial products of one sample item
module ftcm_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ftcm_pkg::dp_sts_t    sts,
  output ftcm_pkg::ctrl_cmd_t  cmd
);
  import ftcm_pkg::*;

  ctrl_state_t state_r, state_nxt;
  logic [2:0]  axis_r, axis_nxt;
  logic [2:0]  gcnt_r, gcnt_nxt;
  logic [1:0]  ppcnt_r, ppcnt_nxt;

  // state and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      axis_r  <= '0;
      gcnt_r  <= '0;
      ppcnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      axis_r  <= axis_nxt;
      gcnt_r  <= gcnt_nxt;
      ppcnt_r <= ppcnt_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt      = state_r;
    axis_nxt       = axis_r;
    gcnt_nxt       = gcnt_r;
    ppcnt_nxt      = ppcnt_r;
    cmd            = '0;
    cmd.axis       = axis_r;
    cmd.gidx       = gcnt_r;
    cmd.pp_sel     = ppcnt_r;
    cmd.last       = (axis_r == sts.na - 3'd1);
    unique case (state_r)
      S_IDLE: begin
        cmd.take = 1'b1;
        if (sts.start) begin
          axis_nxt  = '0;
          state_nxt = S_START;
        end
      end
      S_START: begin
        cmd.axis_start = 1'b1;
        gcnt_nxt       = '0;
        ppcnt_nxt      = '0;
        state_nxt      = (sts.ng == 3'd0) ? S_PP : S_DOT;
      end
      S_DOT: begin
        cmd.issue = 1'b1;
        if (gcnt_r == sts.ng - 3'd1) begin
          state_nxt = S_WAIT;
        end else begin
          gcnt_nxt = gcnt_r + 3'd1;
        end
      end
      S_WAIT: begin
        if (!sts.pipe_busy) begin
          state_nxt = S_PP;
        end
      end
      S_PP: begin
        cmd.pp_step = 1'b1;
        if (ppcnt_r == 2'd3) begin
          state_nxt = S_PPEND;
        end else begin
          ppcnt_nxt = ppcnt_r + 2'd1;
        end
      end
      S_PPEND: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          if (cmd.last) begin
            state_nxt = S_IDLE;
          end else begin
            axis_nxt  = axis_r + 3'd1;
            state_nxt = S_START;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// File: hdl/ftcm_dp.sv
// datapath: tables, bias, dot product, scaling multiply and output register
module ftcm_dp #(
  parameter int AXES  = ftcm_pkg::AXES_DEFAULT,
  parameter int GAGES = ftcm_pkg::GAGES_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  ftcm_pkg::in_item_t            in_data,
  input  logic                          cfg_we,
  input  logic [ftcm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ftcm_pkg::CFG_W-1:0]    cfg_data,
  input  ftcm_pkg::ctrl_cmd_t           cmd,
  output ftcm_pkg::dp_sts_t             sts,
  output logic                          out_valid,
  input  logic                          out_stall,
  output ftcm_pkg::out_item_t           out_data
);
  import ftcm_pkg::*;

  localparam int NA_MAX = (AXES < GAGE_FIELDS) ? AXES : GAGE_FIELDS;
  localparam int BG     = (GAGES < GAGE_FIELDS) ? GAGES : GAGE_FIELDS;
  localparam int CDEPTH = AXES * GAGES;
  localparam int CAW    = (CDEPTH > 1) ? $clog2(CDEPTH) : 1;
  localparam int AIW    = (AXES > 1) ? $clog2(AXES) : 1;
  localparam int BIW    = (BG > 1) ? $clog2(BG) : 1;

  logic                     in_accept;
  logic signed [GAGE_W-1:0] in_gage [GAGE_FIELDS];

  logic [2:0]               act_axes_r;
  logic [2:0]               act_gages_r;
  logic [23:0]              gain_r;
  logic [2:0]               na;
  logic [2:0]               ng;

  logic                     coef_we;
  logic [CAW-1:0]           coef_waddr;
  logic [CAW-1:0]           coef_raddr;
  logic [COEF_W-1:0]        coef_rdata;
  logic                     cvld_r [CDEPTH];

  logic signed [COEF_W-1:0] scale_r [AXES];
  logic signed [GAGE_W-1:0] bias_r [BG];
  logic                     bias_on_r;
  logic signed [GAGE_W-1:0] gage_r [BG];

  logic [BIW-1:0]           gi;
  logic [AIW-1:0]           ai;
  logic signed [CORR_W-1:0] corr_nxt;
  logic signed [CORR_W-1:0] corr_r;
  logic                     cv_r;
  logic                     rd_vld_r;
  logic signed [COEF_W-1:0] coef_q;
  logic signed [MUL_W-1:0]  mul_r;
  logic                     mul_vld_r;
  logic signed [SUM_W-1:0]  acc_r;
  logic signed [SG_W-1:0]   sg_r;

  logic signed [OP_W-1:0]   op_a;
  logic signed [OP_W-1:0]   op_b;
  logic signed [PP_W-1:0]   pp_r;
  logic [1:0]               pp_sh_r;
  logic                     pp_vld_r;
  logic signed [P_W-1:0]    pp_ext;
  logic signed [P_W-1:0]    pp_add;
  logic signed [P_W-1:0]    p_acc_r;

  logic                     fits;
  out_item_t                res;
  logic                     out_valid_r;
  out_item_t                out_data_r;

  assign in_accept = in_valid & cmd.take;

  // gage fields as an array
  assign in_gage[0] = in_data.gage_0;
  assign in_gage[1] = in_data.gage_1;
  assign in_gage[2] = in_data.gage_2;
  assign in_gage[3] = in_data.gage_3;
  assign in_gage[4] = in_data.gage_4;
  assign in_gage[5] = in_data.gage_5;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_axes_r  <= '0;
      act_gages_r <= '0;
      gain_r      <= GAIN_RESET;
    end else if (cfg_we) begin
      priority case (cfg_index)
        CFG_ACTIVE_AXES:  act_axes_r  <= cfg_data[2:0];
        CFG_ACTIVE_GAGES: act_gages_r <= cfg_data[2:0];
        CFG_GAIN_FACTOR:  gain_r      <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  // clamp axis and gage counts; gages past the input fields add nothing
  assign na = (act_axes_r > 3'(NA_MAX)) ? 3'(NA_MAX) : act_axes_r;
  assign ng = (act_gages_r > 3'(BG)) ? 3'(BG) : act_gages_r;

  // coefficient memory with per-entry valid bits
  assign coef_we = in_accept && (in_data.kind == KIND_COEF) &&
                   (int'(in_data.row) < AXES) && (int'(in_data.column) < GAGES);
  assign coef_waddr = CAW'(in_data.row) * CAW'(GAGES) + CAW'(in_data.column);
  assign coef_raddr = CAW'(cmd.axis) * CAW'(GAGES) + CAW'(cmd.gidx);

  ftcm_ram #(
    .WIDTH (COEF_W),
    .DEPTH (CDEPTH)
  ) u_coef_ram (
    .clk   (clk),
    .we    (coef_we),
    .waddr (coef_waddr),
    .wdata (in_data.coefficient),
    .re    (cmd.issue),
    .raddr (coef_raddr),
    .rdata (coef_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CDEPTH; i++) begin
        cvld_r[i] <= 1'b0;
      end
    end else if (coef_we) begin
      cvld_r[coef_waddr] <= 1'b1;
    end
  end

  // axis scales
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < AXES; i++) begin
        scale_r[i] <= '0;
      end
    end else if (in_accept && (in_data.kind == KIND_SCALE) && (int'(in_data.row) < AXES)) begin
      scale_r[AIW'(in_data.row)] <= in_data.coefficient;
    end
  end

  // bias capture and clear
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bias_on_r <= 1'b0;
      for (int i = 0; i < BG; i++) begin
        bias_r[i] <= '0;
      end
    end else if (in_accept && (in_data.kind == KIND_TARE)) begin
      bias_on_r <= 1'b1;
      for (int i = 0; i < BG; i++) begin
        if (i < int'(ng)) begin
          bias_r[i] <= in_gage[i];
        end
      end
    end else if (in_accept && (in_data.kind == KIND_CLEAR)) begin
      bias_on_r <= 1'b0;
      for (int i = 0; i < BG; i++) begin
        bias_r[i] <= '0;
      end
    end
  end

  // sample readings held for the whole item
  always_ff @(posedge clk) begin
    if (in_accept && (in_data.kind == KIND_SAMPLE)) begin
      for (int i = 0; i < BG; i++) begin
        gage_r[i] <= in_gage[i];
      end
    end
  end

  // bias-corrected reading of the gage being issued
  assign gi = BIW'(cmd.gidx);
  assign ai = AIW'(cmd.axis);
  assign corr_nxt = CORR_W'(gage_r[gi]) -
                    (bias_on_r ? CORR_W'(bias_r[gi]) : CORR_W'(0));

  // dot product pipeline: read, multiply, accumulate
  assign coef_q = cv_r ? signed'(coef_rdata) : COEF_W'(0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r  <= 1'b0;
      mul_vld_r <= 1'b0;
      pp_vld_r  <= 1'b0;
    end else begin
      rd_vld_r  <= cmd.issue;
      mul_vld_r <= rd_vld_r;
      pp_vld_r  <= cmd.pp_step;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      corr_r <= corr_nxt;
      cv_r   <= cvld_r[coef_raddr];
    end
    if (rd_vld_r) begin
      mul_r <= coef_q * corr_r;
    end
    if (cmd.axis_start) begin
      acc_r <= '0;
      sg_r  <= scale_r[ai] * signed'({1'b0, gain_r});
    end else if (mul_vld_r) begin
      acc_r <= acc_r + SUM_W'(mul_r);
    end
  end

  // row sum times scale-gain, one 26x26 partial product a cycle
  assign op_a = cmd.pp_sel[1] ? OP_W'(signed'(acc_r[SUM_W-1:PP_SPLIT]))
                              : signed'({2'b00, acc_r[PP_SPLIT-1:0]});
  assign op_b = cmd.pp_sel[0] ? OP_W'(signed'(sg_r[SG_W-1:PP_SPLIT]))
                              : signed'({2'b00, sg_r[PP_SPLIT-1:0]});
  assign pp_ext = P_W'(pp_r);

  always_comb begin
    unique case (pp_sh_r)
      2'd0:    pp_add = pp_ext;
      2'd1:    pp_add = pp_ext <<< PP_SPLIT;
      2'd2:    pp_add = pp_ext <<< (2 * PP_SPLIT);
      default: pp_add = pp_ext;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.pp_step) begin
      pp_r    <= op_a * op_b;
      pp_sh_r <= {1'b0, cmd.pp_sel[1]} + {1'b0, cmd.pp_sel[0]};
    end
    if (cmd.axis_start) begin
      p_acc_r <= '0;
    end else if (pp_vld_r) begin
      p_acc_r <= p_acc_r + pp_add;
    end
  end

  // floor shift by 32 and saturate
  assign fits = (&p_acc_r[P_W-1:VAL_W+31]) | ~(|p_acc_r[P_W-1:VAL_W+31]);

  always_comb begin
    res.axis      = cmd.axis;
    res.last      = cmd.last;
    res.saturated = ~fits;
    if (fits) begin
      res.value = p_acc_r[VAL_W+31:VAL_W];
    end else if (p_acc_r[P_W-1]) begin
      res.value = {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      res.value = {1'b0, {(VAL_W-1){1'b1}}};
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // status to the controller
  assign sts.start     = in_accept && (in_data.kind == KIND_SAMPLE) && (na != 3'd0);
  assign sts.na        = na;
  assign sts.ng        = ng;
  assign sts.pipe_busy = rd_vld_r | mul_vld_r;
  assign sts.out_free  = ~out_valid_r | ~out_stall;

endmodule
